### rtl/afnd_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// afnd_pkg
// Shared types and constants of the aspect-fit nearest downscaler.
// -----------------------------------------------------------------------------
package afnd_pkg;

    localparam int DIM_W      = 13;
    localparam int PIX_W      = 32;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [DIM_W-1:0] MAX_DIM      = 13'd4096;
    localparam logic [DIM_W-1:0] RESET_MAX_W  = 13'd1280;
    localparam logic [DIM_W-1:0] RESET_MAX_H  = 13'd720;
    localparam logic [PIX_W-1:0] ALPHA_ONES   = 32'hFF000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_OUT_WIDTH  = 1'b0,
        REG_MAX_OUT_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_FETCH,
        S_MUL,
        S_FIT,
        S_FIT_WAIT,
        S_COL_DIV,
        S_COL_WAIT,
        S_ROW_DIV,
        S_ROW_WAIT,
        S_PROC
    } seq_state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quot;
        logic [DIM_W-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

### rtl/afnd_fifo.sv
`default_nettype none
// -----------------------------------------------------------------------------
// afnd_fifo
// Small show-ahead queue built from registers.
// -----------------------------------------------------------------------------
module afnd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/afnd_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// afnd_div
// Restoring divider, one quotient bit per cycle, for per-frame setup.
// -----------------------------------------------------------------------------
module afnd_div
    import afnd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(PROD_W);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIM_W:0]    acc;
    logic [DIM_W:0]    diff;

    assign acc  = {rem_reg, quo_reg[PROD_W-1]};
    assign diff = acc - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (acc >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIM_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = acc[DIM_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg[DIM_W-1:0];
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

### rtl/afnd_seq.sv
`default_nettype none
// -----------------------------------------------------------------------------
// afnd_seq
// Back-end sequencer: per-frame fit and step setup, then pixel selection.
// -----------------------------------------------------------------------------
module afnd_seq
    import afnd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 in_empty,
    output logic                      in_pop,
    input  wire logic [PIX_W-1:0]     in_pixel,
    input  wire logic [DIM_W-1:0]     in_width,
    input  wire logic [DIM_W-1:0]     in_height,
    input  wire logic                 in_sof,
    input  wire logic                 out_full,
    output logic                      out_push,
    output logic [PIX_W-1:0]          res_pixel,
    output logic [DIM_W-1:0]          res_width,
    output logic [DIM_W-1:0]          res_height,
    output logic                      res_eor,
    output logic                      res_last,
    output div_req_t                  div_req,
    input  wire div_rsp_t             div_rsp
);

    seq_state_t state_reg, state_next;

    logic [DIM_W-1:0]  max_w_reg, max_h_reg;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [DIM_W-1:0]  src_w_reg, src_w_next, src_h_reg, src_h_next;
    logic [DIM_W-1:0]  dst_w_reg, dst_w_next, dst_h_reg, dst_h_next;
    logic [DIM_W-1:0]  src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [DIM_W:0]    want_col_reg, want_col_next, want_row_reg, want_row_next;
    logic [DIM_W:0]    col_rem_reg, col_rem_next, row_rem_reg, row_rem_next;
    logic [DIM_W-1:0]  col_whole_reg, col_whole_next, col_frac_reg, col_frac_next;
    logic [DIM_W-1:0]  row_whole_reg, row_whole_next, row_frac_reg, row_frac_next;
    logic [DIM_W-1:0]  dst_col_reg, dst_col_next, dst_row_reg, dst_row_next;
    logic              active_reg, active_next;
    logic [PROD_W-1:0] pw_reg, pw_next, ph_reg, ph_next;
    logic              wide_reg, wide_next;

    logic [DIM_W-1:0]  cfg_val;
    logic              start_ok;
    logic              oversized;
    logic              wide_cmp;
    logic              row_taken;
    logic              hit;
    logic              do_step;
    logic [DIM_W:0]    col_sum, row_sum;
    logic [DIM_W:0]    want_col_adv, want_row_adv;
    logic [DIM_W-1:0]  quot_min1;

    assign cfg_val   = (cfg_data == '0) ? DIM_W'(1) : cfg_data;
    assign start_ok  = (in_width != '0) && (in_height != '0);
    assign oversized = (src_w_reg > max_w_reg) || (src_h_reg > max_h_reg);
    assign wide_cmp  = (pw_reg > ph_reg);
    assign row_taken = ({1'b0, src_row_reg} == want_row_reg);
    assign hit       = row_taken && ({1'b0, src_col_reg} == want_col_reg);
    assign do_step   = (state_reg == S_PROC) && !out_full && active_reg;
    assign col_sum   = col_rem_reg + {1'b0, col_frac_reg};
    assign row_sum   = row_rem_reg + {1'b0, row_frac_reg};
    assign want_col_adv = want_col_reg + {1'b0, col_whole_reg};
    assign want_row_adv = want_row_reg + {1'b0, row_whole_reg};
    assign quot_min1 = (div_rsp.quot == '0) ? DIM_W'(1) : div_rsp.quot;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_FETCH:
            begin
                if (!in_empty)
                begin
                    state_next = (in_sof && start_ok) ? S_MUL : S_PROC;
                end
            end
            S_MUL:      state_next = S_FIT;
            S_FIT:      state_next = oversized ? S_FIT_WAIT : S_COL_DIV;
            S_FIT_WAIT: state_next = div_rsp.done ? S_COL_DIV : S_FIT_WAIT;
            S_COL_DIV:  state_next = S_COL_WAIT;
            S_COL_WAIT: state_next = div_rsp.done ? S_ROW_DIV : S_COL_WAIT;
            S_ROW_DIV:  state_next = S_ROW_WAIT;
            S_ROW_WAIT: state_next = div_rsp.done ? S_PROC : S_ROW_WAIT;
            S_PROC:     state_next = out_full ? S_PROC : S_FETCH;
            default:    state_next = S_FETCH;
        endcase
    end

    always_comb
    begin
        in_pop           = (state_reg == S_FETCH) && !in_empty;
        out_push         = do_step && hit;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DIM_W'(1);
        unique case (state_reg)
            S_FIT:
            begin
                div_req.start    = oversized;
                div_req.dividend = wide_cmp ? ph_reg : pw_reg;
                div_req.divisor  = wide_cmp ? src_w_reg : src_h_reg;
            end
            S_COL_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = PROD_W'(src_w_reg);
                div_req.divisor  = dst_w_reg;
            end
            S_ROW_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = PROD_W'(src_h_reg);
                div_req.divisor  = dst_h_reg;
            end
            default:
            begin
            end
        endcase
        res_pixel  = pix_reg | ALPHA_ONES;
        res_width  = dst_w_reg;
        res_height = dst_h_reg;
        res_eor    = ((dst_col_reg + 1'b1) == dst_w_reg);
        res_last   = res_eor && ((dst_row_reg + 1'b1) == dst_h_reg);
    end

    always_comb
    begin
        pix_next       = pix_reg;
        src_w_next     = src_w_reg;
        src_h_next     = src_h_reg;
        dst_w_next     = dst_w_reg;
        dst_h_next     = dst_h_reg;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        want_col_next  = want_col_reg;
        want_row_next  = want_row_reg;
        col_rem_next   = col_rem_reg;
        row_rem_next   = row_rem_reg;
        col_whole_next = col_whole_reg;
        col_frac_next  = col_frac_reg;
        row_whole_next = row_whole_reg;
        row_frac_next  = row_frac_reg;
        dst_col_next   = dst_col_reg;
        dst_row_next   = dst_row_reg;
        active_next    = active_reg;
        pw_next        = pw_reg;
        ph_next        = ph_reg;
        wide_next      = wide_reg;
        case (state_reg)
            S_FETCH:
            begin
                if (!in_empty)
                begin
                    pix_next = in_pixel;
                    if (in_sof)
                    begin
                        src_w_next    = (in_width > MAX_DIM) ? MAX_DIM : in_width;
                        src_h_next    = (in_height > MAX_DIM) ? MAX_DIM : in_height;
                        active_next   = start_ok;
                        src_col_next  = '0;
                        src_row_next  = '0;
                        dst_row_next  = '0;
                        want_row_next = '0;
                        row_rem_next  = '0;
                        want_col_next = '0;
                        col_rem_next  = '0;
                        dst_col_next  = '0;
                    end
                end
            end
            S_MUL:
            begin
                pw_next = src_w_reg * max_h_reg;
                ph_next = src_h_reg * max_w_reg;
            end
            S_FIT:
            begin
                wide_next = wide_cmp;
                if (!oversized)
                begin
                    dst_w_next = src_w_reg;
                    dst_h_next = src_h_reg;
                end
                else if (wide_cmp)
                begin
                    dst_w_next = max_w_reg;
                end
                else
                begin
                    dst_h_next = max_h_reg;
                end
            end
            S_FIT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (wide_reg)
                    begin
                        dst_h_next = quot_min1;
                    end
                    else
                    begin
                        dst_w_next = quot_min1;
                    end
                end
            end
            S_COL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    col_whole_next = div_rsp.quot;
                    col_frac_next  = div_rsp.rem;
                end
            end
            S_ROW_WAIT:
            begin
                if (div_rsp.done)
                begin
                    row_whole_next = div_rsp.quot;
                    row_frac_next  = div_rsp.rem;
                end
            end
            S_PROC:
            begin
                if (do_step)
                begin
                    if (hit)
                    begin
                        if (col_sum >= {1'b0, dst_w_reg})
                        begin
                            col_rem_next  = col_sum - {1'b0, dst_w_reg};
                            want_col_next = want_col_adv + 1'b1;
                        end
                        else
                        begin
                            col_rem_next  = col_sum;
                            want_col_next = want_col_adv;
                        end
                        dst_col_next = dst_col_reg + 1'b1;
                    end
                    if (({1'b0, src_col_reg} + 1'b1) < {1'b0, src_w_reg})
                    begin
                        src_col_next = src_col_reg + 1'b1;
                    end
                    else
                    begin
                        src_col_next  = '0;
                        want_col_next = '0;
                        col_rem_next  = '0;
                        dst_col_next  = '0;
                        if (row_taken)
                        begin
                            if (row_sum >= {1'b0, dst_h_reg})
                            begin
                                row_rem_next  = row_sum - {1'b0, dst_h_reg};
                                want_row_next = want_row_adv + 1'b1;
                            end
                            else
                            begin
                                row_rem_next  = row_sum;
                                want_row_next = want_row_adv;
                            end
                            dst_row_next = dst_row_reg + 1'b1;
                        end
                        src_row_next = src_row_reg + 1'b1;
                        if (({1'b0, src_row_reg} + 1'b1) >= {1'b0, src_h_reg})
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FETCH;
            max_w_reg     <= RESET_MAX_W;
            max_h_reg     <= RESET_MAX_H;
            src_w_reg     <= '0;
            src_h_reg     <= '0;
            dst_w_reg     <= '0;
            dst_h_reg     <= '0;
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            want_col_reg  <= '0;
            want_row_reg  <= '0;
            col_rem_reg   <= '0;
            row_rem_reg   <= '0;
            col_whole_reg <= '0;
            col_frac_reg  <= '0;
            row_whole_reg <= '0;
            row_frac_reg  <= '0;
            dst_col_reg   <= '0;
            dst_row_reg   <= '0;
            active_reg    <= 1'b0;
            wide_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MAX_OUT_WIDTH:  max_w_reg <= cfg_val;
                    REG_MAX_OUT_HEIGHT: max_h_reg <= cfg_val;
                    default:
                    begin
                    end
                endcase
            end
            src_w_reg     <= src_w_next;
            src_h_reg     <= src_h_next;
            dst_w_reg     <= dst_w_next;
            dst_h_reg     <= dst_h_next;
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            want_col_reg  <= want_col_next;
            want_row_reg  <= want_row_next;
            col_rem_reg   <= col_rem_next;
            row_rem_reg   <= row_rem_next;
            col_whole_reg <= col_whole_next;
            col_frac_reg  <= col_frac_next;
            row_whole_reg <= row_whole_next;
            row_frac_reg  <= row_frac_next;
            dst_col_reg   <= dst_col_next;
            dst_row_reg   <= dst_row_next;
            active_reg    <= active_next;
            wide_reg      <= wide_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        pw_reg  <= pw_next;
        ph_reg  <= ph_next;
    end

endmodule
`default_nettype wire

### rtl/aspect_fit_nearest_downscaler_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// aspect_fit_nearest_downscaler_core
// Nearest-neighbor downscaler that fits each frame inside a programmable box.
// Path: a pushed pixel passes through the input queue, the sequencer's fetch and
// process states and the output queue; a start-of-frame pixel of a nonzero frame
// first waits for three 26-step divisions, or two when the frame fits the box.
// The fetch/process sequencer takes one pixel at a time and stalls on a full output queue.
// Reset: queues empty, no frame active, box limits 1280 x 720.
// -----------------------------------------------------------------------------
module aspect_fit_nearest_downscaler_core
    import afnd_pkg::*;
#(
    parameter int IN_DEPTH  = IN_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [PIX_W-1:0]     src_pixel,
    input  wire logic [DIM_W-1:0]     frame_width,
    input  wire logic [DIM_W-1:0]     frame_height,
    input  wire logic                 start_of_frame,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [PIX_W-1:0]          out_pixel,
    output logic [DIM_W-1:0]          out_width,
    output logic [DIM_W-1:0]          out_height,
    output logic                      end_of_row,
    output logic                      last_of_frame
);

    localparam int IN_W  = PIX_W + 2 * DIM_W + 1;
    localparam int OUT_W = PIX_W + 2 * DIM_W + 2;

    logic [IN_W-1:0]  in_wdata, in_rdata;
    logic [OUT_W-1:0] out_wdata, out_rdata;
    logic             in_empty, in_pop;
    logic             out_full, out_push;
    logic [PIX_W-1:0] res_pixel;
    logic [DIM_W-1:0] res_width, res_height;
    logic             res_eor, res_last;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign in_wdata = {src_pixel, frame_width, frame_height, start_of_frame};

    afnd_fifo #(.WIDTH(IN_W), .DEPTH(IN_DEPTH)) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_wdata),
        .full    (full),
        .rd_en   (in_pop),
        .rd_data (in_rdata),
        .empty   (in_empty)
    );

    afnd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    afnd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_empty   (in_empty),
        .in_pop     (in_pop),
        .in_pixel   (in_rdata[IN_W-1 -: PIX_W]),
        .in_width   (in_rdata[2*DIM_W -: DIM_W]),
        .in_height  (in_rdata[DIM_W -: DIM_W]),
        .in_sof     (in_rdata[0]),
        .out_full   (out_full),
        .out_push   (out_push),
        .res_pixel  (res_pixel),
        .res_width  (res_width),
        .res_height (res_height),
        .res_eor    (res_eor),
        .res_last   (res_last),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    assign out_wdata = {res_pixel, res_width, res_height, res_eor, res_last};

    afnd_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wdata),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rdata),
        .empty   (empty)
    );

    assign out_pixel     = out_rdata[OUT_W-1 -: PIX_W];
    assign out_width     = out_rdata[2*DIM_W+1 -: DIM_W];
    assign out_height    = out_rdata[DIM_W+1 -: DIM_W];
    assign end_of_row    = out_rdata[1];
    assign last_of_frame = out_rdata[0];

endmodule
`default_nettype wire

### rtl/afnd_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// afnd_checker
// Port-level checks of the downscaler, bound to the top level.
// -----------------------------------------------------------------------------
module afnd_checker
    import afnd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [PIX_W-1:0] out_pixel,
    input wire logic [DIM_W-1:0] out_width,
    input wire logic [DIM_W-1:0] out_height,
    input wire logic             end_of_row,
    input wire logic             last_of_frame
);

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_frame) |-> end_of_row)
        else $error("last_of_frame without end_of_row");

    a_alpha_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_pixel[PIX_W-1 -: 8] == 8'hFF))
        else $error("alpha byte not forced");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((out_width != '0) && (out_height != '0)))
        else $error("zero output dimension");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("pending result dropped");

endmodule

bind aspect_fit_nearest_downscaler_core afnd_checker u_afnd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .out_pixel     (out_pixel),
    .out_width     (out_width),
    .out_height    (out_height),
    .end_of_row    (end_of_row),
    .last_of_frame (last_of_frame)
);
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random-size source frames through the aspect-fit downscaler and
// compares each output pixel against an in-bench scaler that tracks source
// and destination positions the same way, across several output box limits.
// ----------------------------------------------------------------------------
module testbench;
    import afnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             sof;
    } src_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             eor;
        logic             lof;
    } scaled_px_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    cfg_reg_t cfg_index = REG_MAX_OUT_WIDTH;
    logic [DIM_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic [PIX_W-1:0] src_pixel = '0;
    logic [DIM_W-1:0] frame_width = '0;
    logic [DIM_W-1:0] frame_height = '0;
    logic start_of_frame = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [PIX_W-1:0] out_pixel;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic end_of_row;
    logic last_of_frame;

    aspect_fit_nearest_downscaler_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .src_pixel(src_pixel), .frame_width(frame_width),
        .frame_height(frame_height), .start_of_frame(start_of_frame),
        .empty(empty), .pop(pop),
        .out_pixel(out_pixel), .out_width(out_width), .out_height(out_height),
        .end_of_row(end_of_row), .last_of_frame(last_of_frame)
    );

    src_req_t   pending_px[$];
    scaled_px_t expected_px[$];
    int mismatches = 0;
    int unsigned cycle = 0;
    bit calm = 1'b0;

    // scaler state
    int unsigned box_w = 1280, box_h = 720;
    int unsigned sw, sh, dw, dh, scol, srow, wcol, crem, cwhole, cfrac;
    int unsigned wrow, rrem, rwhole, rfrac, dcol, drow;
    bit active = 1'b0;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
    endfunction

    function automatic int unsigned nonzero(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic scale_pixel(src_req_t r);
        longint unsigned pw, ph;
        bit row_hit;
        scaled_px_t o;
        if (r.sof)
        begin
            sw = clamp_dim(r.w);
            sh = clamp_dim(r.h);
            active = (sw != 0 && sh != 0);
            scol = 0; srow = 0; drow = 0; wrow = 0; rrem = 0;
            wcol = 0; crem = 0; dcol = 0;
            if (active)
            begin
                dw = sw;
                dh = sh;
                if (sw > box_w || sh > box_h)
                begin
                    pw = longint'(sw) * box_h;
                    ph = longint'(sh) * box_w;
                    if (pw > ph)
                    begin
                        dw = box_w;
                        dh = nonzero(int'(longint'(sh) * box_w / sw));
                    end
                    else
                    begin
                        dh = box_h;
                        dw = nonzero(int'(longint'(sw) * box_h / sh));
                    end
                end
                cwhole = sw / dw; cfrac = sw % dw;
                rwhole = sh / dh; rfrac = sh % dh;
            end
        end
        if (!active)
            return;
        row_hit = (srow == wrow);
        if (row_hit && scol == wcol)
        begin
            o.pix = r.pix | ALPHA_ONES;
            o.w = dw[DIM_W-1:0];
            o.h = dh[DIM_W-1:0];
            o.eor = (dcol + 1 == dw);
            o.lof = o.eor && (drow + 1 == dh);
            expected_px.push_back(o);
            wcol += cwhole;
            crem += cfrac;
            if (crem >= dw)
            begin
                crem -= dw;
                wcol++;
            end
            dcol++;
        end
        if (scol + 1 < sw)
        begin
            scol++;
            return;
        end
        scol = 0; wcol = 0; crem = 0; dcol = 0;
        if (row_hit)
        begin
            wrow += rwhole;
            rrem += rfrac;
            if (rrem >= dh)
            begin
                rrem -= dh;
                wrow++;
            end
            drow++;
        end
        srow++;
        if (srow >= sh)
            active = 1'b0;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 3000000)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
            scale_pixel({src_pixel, frame_width, frame_height, start_of_frame});
        if (!(push && full))
        begin
            if (pending_px.size() > 0 && (calm || $urandom_range(99) >= 7))
            begin
                src_req_t r;
                r = pending_px.pop_front();
                push <= 1'b1;
                src_pixel <= r.pix;
                frame_width <= r.w;
                frame_height <= r.h;
                start_of_frame <= r.sof;
            end
            else
                push <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_px.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h", out_pixel);
            end
            else
            begin
                scaled_px_t e;
                e = expected_px.pop_front();
                if (e != {out_pixel, out_width, out_height, end_of_row, last_of_frame})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %0d %0d %b %b got %h %0d %0d %b %b",
                            e.pix, e.w, e.h, e.eor, e.lof, out_pixel, out_width,
                            out_height, end_of_row, last_of_frame);
                end
            end
        end
        pop <= calm || ($urandom_range(99) >= 7);
    end

    task automatic add_frame(int unsigned w, int unsigned h, int unsigned n);
        src_req_t r;
        for (int unsigned i = 0; i < n; i++)
        begin
            r.pix = $urandom;
            r.sof = (i == 0);
            r.w = (i == 0) ? w[DIM_W-1:0] : DIM_W'($urandom);
            r.h = (i == 0) ? h[DIM_W-1:0] : DIM_W'($urandom);
            pending_px.push_back(r);
        end
    endtask

    task automatic drain();
        while (pending_px.size() > 0 || push || expected_px.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_box(int unsigned w, int unsigned h);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_OUT_WIDTH;
        cfg_data <= w[DIM_W-1:0];
        @(posedge clk);
        cfg_index <= REG_MAX_OUT_HEIGHT;
        cfg_data <= h[DIM_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        box_w = nonzero(w);
        box_h = nonzero(h);
    endtask

    initial
    begin
        int unsigned w, h, n, total;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: default box, then special cases
        add_frame(3, 2, 6);
        pending_px.push_back('{32'h00FF_FFFF, 13'd0, 13'd0, 1'b0});
        add_frame(0, 4, 1);
        add_frame(4, 0, 1);
        add_frame(2, 2, 2);
        add_frame(1, 1, 1);
        add_frame(8191, 1, 3);
        pending_px.push_back('{32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF, 1'b1});
        pending_px.push_back('{32'h0000_0000, 13'd0, 13'd0, 1'b0});
        drain();
        set_box(0, 0);
        add_frame(3, 3, 9);
        drain();
        set_box(4096, 4096);
        add_frame(2, 3, 6);
        drain();
        set_box(8191, 2);
        add_frame(5, 4, 20);
        drain();
        total = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_box($urandom_range(1, 6), $urandom_range(1, 6));
            calm = (phase == 2);
            while (total < (phase + 1) * 500)
            begin
                w = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(12);
                h = ($urandom_range(19) == 0) ? $urandom_range(8191) : $urandom_range(8);
                if (w > 12 || h > 8)
                    n = $urandom_range(1, 30);
                else if ($urandom_range(9) == 0)
                    n = $urandom_range(1, w * h + 3);
                else
                    n = w * h;
                if (n == 0)
                    n = 1;
                add_frame(w, h, n);
                total += n;
            end
            drain();
        end
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
